FILE: rtl/core/ccde_pkg.sv
package ccde_pkg;

    localparam int CHUNK_BYTES_DEF = 32;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Header byte positions of a delta record
    localparam logic [2:0] HDR_OFS_B0 = 3'd0;
    localparam logic [2:0] HDR_OFS_B1 = 3'd1;
    localparam logic [2:0] HDR_OFS_B2 = 3'd2;
    localparam logic [2:0] HDR_OFS_B3 = 3'd3;
    localparam logic [2:0] HDR_LEN_LO = 3'd4;
    localparam logic [2:0] HDR_LEN_HI = 3'd5;

    typedef struct packed {
        logic take;
        logic emit_hdr;
        logic emit_data;
        logic emit_done;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic differ;
        logic last_in;
        logic hdr_last;
        logic data_last;
        logic out_free;
    } stat_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/ccde_dpath.sv
module ccde_dpath #(
    parameter int CHUNK_BYTES = ccde_pkg::CHUNK_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ccde_pkg::cmd_t   cmd,
    output ccde_pkg::stat_t  stat,
    input  logic [7:0]       new_byte,
    input  logic [7:0]       old_byte,
    input  logic             last_in,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             has_byte,
    output logic             record_end,
    output logic             stream_done,
    output logic [31:0]      delta_length
);
    import ccde_pkg::*;

    localparam int AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int FW = $clog2(CHUNK_BYTES + 1);
    localparam logic [FW-1:0] FillFull = FW'(CHUNK_BYTES);

    logic [7:0]    mem [CHUNK_BYTES];
    logic [7:0]    rd_data_reg;

    logic [31:0]   crc_new_reg, crc_new_next;
    logic [31:0]   crc_old_reg, crc_old_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] len_reg, len_next;
    logic          last_reg, last_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   emitted_reg, emitted_next;
    logic [2:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          has_reg, has_next;
    logic          rend_reg, rend_next;
    logic          done_reg, done_next;
    logic [31:0]   dlen_reg, dlen_next;

    logic [FW-1:0] fill_inc;
    logic [31:0]   crc_new_upd;
    logic [31:0]   crc_old_upd;
    logic          last_eff;
    logic [FW-1:0] len_eff;
    logic [7:0]    hdr_byte;

    assign fill_inc    = fill_reg + FW'(1);
    assign crc_new_upd = crc_byte(crc_new_reg, new_byte);
    assign crc_old_upd = crc_byte(crc_old_reg, old_byte);
    assign last_eff    = cmd.take ? last_in : last_reg;
    assign len_eff     = cmd.take ? fill_inc : len_reg;

    assign stat.close     = (fill_inc == FillFull) || last_in;
    assign stat.differ    = crc_new_upd != crc_old_upd;
    assign stat.last_in   = last_in;
    assign stat.hdr_last  = hdr_cnt_reg == HDR_LEN_HI;
    assign stat.data_last = (FW'(idx_reg) + FW'(1)) == len_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb begin
        unique case (hdr_cnt_reg)
            HDR_OFS_B0: hdr_byte = offset_reg[7:0];
            HDR_OFS_B1: hdr_byte = offset_reg[15:8];
            HDR_OFS_B2: hdr_byte = offset_reg[23:16];
            HDR_OFS_B3: hdr_byte = offset_reg[31:24];
            HDR_LEN_LO: hdr_byte = 8'(len_reg);
            HDR_LEN_HI: hdr_byte = 8'd0;
            default:    hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        crc_new_next = crc_new_reg;
        crc_old_next = crc_old_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        offset_next  = offset_reg;
        emitted_next = emitted_reg;
        hdr_cnt_next = hdr_cnt_reg;
        idx_next     = idx_reg;

        if (cmd.take) begin
            fill_next    = stat.close ? '0 : fill_inc;
            crc_new_next = stat.close ? CRC_INIT : crc_new_upd;
            crc_old_next = stat.close ? CRC_INIT : crc_old_upd;
            len_next     = fill_inc;
            last_next    = last_in;
            hdr_cnt_next = '0;
            idx_next     = '0;
        end
        if (cmd.emit_hdr) begin
            hdr_cnt_next = hdr_cnt_reg + 3'd1;
        end
        if (cmd.emit_data) begin
            idx_next = stat.data_last ? '0 : idx_reg + AW'(1);
        end
        if (cmd.emit_hdr || cmd.emit_data) begin
            emitted_next = emitted_reg + 32'd1;
        end
        if (cmd.finish) begin
            offset_next = last_eff ? 32'd0 : offset_reg + 32'(len_eff);
            if (last_eff) begin
                emitted_next = 32'd0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        has_next       = has_reg;
        rend_next      = rend_reg;
        done_next      = done_reg;
        dlen_next      = dlen_reg;
        priority if (cmd.emit_hdr) begin
            out_valid_next = 1'b1;
            out_byte_next  = hdr_byte;
            has_next       = 1'b1;
            rend_next      = 1'b0;
            done_next      = 1'b0;
            dlen_next      = emitted_reg + 32'd1;
        end else if (cmd.emit_data) begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            has_next       = 1'b1;
            rend_next      = stat.data_last;
            done_next      = stat.data_last && last_reg;
            dlen_next      = emitted_reg + 32'd1;
        end else if (cmd.emit_done) begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            has_next       = 1'b0;
            rend_next      = 1'b0;
            done_next      = 1'b1;
            dlen_next      = emitted_reg;
        end else begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // chunk buffer: write on take, read follows the next data index
    always_ff @(posedge clk) begin
        if (cmd.take) begin
            mem[fill_reg[AW-1:0]] <= new_byte;
        end
        rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            crc_new_reg   <= CRC_INIT;
            crc_old_reg   <= CRC_INIT;
            fill_reg      <= '0;
            len_reg       <= '0;
            last_reg      <= 1'b0;
            offset_reg    <= 32'd0;
            emitted_reg   <= 32'd0;
            hdr_cnt_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            crc_new_reg   <= crc_new_next;
            crc_old_reg   <= crc_old_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            offset_reg    <= offset_next;
            emitted_reg   <= emitted_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        out_byte_reg <= out_byte_next;
        has_reg      <= has_next;
        rend_reg     <= rend_next;
        done_reg     <= done_next;
        dlen_reg     <= dlen_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign has_byte     = has_reg;
    assign record_end   = rend_reg;
    assign stream_done  = done_reg;
    assign delta_length = dlen_reg;

endmodule

FILE: rtl/core/ccde_ctrl.sv
module ccde_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pair_valid,
    input  ccde_pkg::stat_t stat,
    output ccde_pkg::cmd_t  cmd,
    output logic            pair_stall
);
    import ccde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_DATA = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.take = pair_valid;
                if (pair_valid && stat.close) begin
                    priority if (stat.differ) begin
                        state_next = S_HDR;
                    end else if (stat.last_in) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.finish = 1'b1;
                    end
                end
            end
            S_HDR: begin
                if (stat.out_free) begin
                    cmd.emit_hdr = 1'b1;
                    if (stat.hdr_last) begin
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (stat.out_free) begin
                    cmd.emit_data = 1'b1;
                    if (stat.data_last) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_done = 1'b1;
                    cmd.finish    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign pair_stall = state_reg != S_IDLE;

endmodule

FILE: rtl/core/chunk_crc_delta_encoder.sv
// Channel  Direction  Handshake                 Word
// pair     in         pair_valid / pair_stall   new_byte, old_byte, last_in
// delta    out        delta_valid / delta_stall out_byte, has_byte, record_end,
//                                               stream_done, delta_length
//
// A pair word that does not close a chunk is taken without holding the pair channel.
// A closing word whose CRCs differ holds the pair channel while its six
// header bytes and chunk bytes go out, one record byte per cycle out of the
// output register unless stalled; an end of stream with matching CRCs holds
// it for the done word; the output register sets this pace.
// Reset clears the CRCs, counters and output valid; the chunk buffer needs no
// clearing pass, since only bytes written in the current chunk are read.
// A stalled delta word holds in the output register while the sequencer waits.
module chunk_crc_delta_encoder #(
    parameter int CHUNK_BYTES = ccde_pkg::CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_stall,
    input  logic [7:0]  new_byte,
    input  logic [7:0]  old_byte,
    input  logic        last_in,
    output logic        delta_valid,
    input  logic        delta_stall,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        record_end,
    output logic        stream_done,
    output logic [31:0] delta_length
);
    import ccde_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: take a pair word, then walk header and chunk bytes or the done word out
    ccde_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .stat       (stat),
        .cmd        (cmd),
        .pair_stall (pair_stall)
    );

    // Datapath: CRC pair, chunk buffer, counters and the output register
    ccde_dpath #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .new_byte     (new_byte),
        .old_byte     (old_byte),
        .last_in      (last_in),
        .out_stall    (delta_stall),
        .out_valid    (delta_valid),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .record_end   (record_end),
        .stream_done  (stream_done),
        .delta_length (delta_length)
    );

    // A finished chunk must hand control back to the pair channel
    a_finish_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !pair_stall)
        else $error("pair channel still held after chunk finish");

    // A word that leaves the chunk open must not hold the input
    a_open_chunk_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall && !stat.close) |=> !pair_stall)
        else $error("input held although chunk still open");

    // A record end always carries a delta byte
    a_rend_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (delta_valid && record_end) |-> has_byte)
        else $error("record end without a delta byte");

    // An empty word is only the end-of-stream marker
    a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (delta_valid && !has_byte) |-> (stream_done && out_byte == 8'd0 && !record_end))
        else $error("empty delta word that is not an end marker");

endmodule

FILE: tb/tb_chunk_crc_delta_encoder.sv
module tb_chunk_crc_delta_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ccde_pkg::*;

    localparam int CHUNK      = CHUNK_BYTES_DEF;
    localparam int RAND_ITEMS = 470;
    // Longest record is 6 header bytes plus a full chunk; give the tail room for that.
    localparam int DRAIN_CYCLES = 3 * (CHUNK + 6);
    // Worst case: every word closes a differing chunk, every delta word waits
    // on a heavy stall pattern, plus sender gaps and the long hold-off.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_START  = 700;
    localparam int HOLD_LEN    = 400;

    // One delta word as the block presents it.
    typedef struct packed {
        logic [7:0]  data;
        logic        has_data;
        logic        rec_end;
        logic        done;
        logic [31:0] total;
    } delta_word_t;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic [7:0]  nb;
        logic [7:0]  ob;
        logic        last;
        logic        typed;
        delta_word_t exp;
    } pair_row_t;

    localparam delta_word_t DONE_EMPTY = '{data: 8'h00, has_data: 1'b0, rec_end: 1'b0,
                                           done: 1'b1, total: 32'd0};
    localparam delta_word_t NO_EXP     = '0;
    localparam int N_DIR = 17;

    // Directed part: single-byte streams at the extremes, equal streams that
    // end with an empty done word, and short streams whose chunk differs.
    pair_row_t dir_rows [N_DIR] = '{
        '{8'h00, 8'h00, 1'b1, 1'b1, DONE_EMPTY},   // equal single byte: done only
        '{8'hFF, 8'h00, 1'b1, 1'b0, NO_EXP},       // differing single byte: record
        '{8'hFF, 8'hFF, 1'b1, 1'b1, DONE_EMPTY},
        '{8'h00, 8'hFF, 1'b1, 1'b0, NO_EXP},
        '{8'hA5, 8'hA5, 1'b0, 1'b0, NO_EXP},       // open chunk: no word
        '{8'h5A, 8'h5A, 1'b0, 1'b0, NO_EXP},
        '{8'h01, 8'h01, 1'b0, 1'b0, NO_EXP},
        '{8'h80, 8'h80, 1'b1, 1'b1, DONE_EMPTY},   // equal 4-byte stream
        '{8'h12, 8'h12, 1'b0, 1'b0, NO_EXP},
        '{8'h34, 8'h35, 1'b0, 1'b0, NO_EXP},
        '{8'h56, 8'h56, 1'b0, 1'b0, NO_EXP},
        '{8'h78, 8'h78, 1'b1, 1'b0, NO_EXP},       // 4-byte record, end on last byte
        '{8'hFF, 8'hFF, 1'b0, 1'b0, NO_EXP},
        '{8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
        '{8'hFF, 8'h00, 1'b1, 1'b0, NO_EXP},
        '{8'h7F, 8'h80, 1'b1, 1'b0, NO_EXP},
        '{8'h80, 8'h7F, 1'b1, 1'b0, NO_EXP}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        pair_valid   = 1'b0;
    logic        pair_stall;
    logic [7:0]  new_byte     = 8'h00;
    logic [7:0]  old_byte     = 8'h00;
    logic        last_in      = 1'b0;
    logic        delta_valid;
    logic        delta_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        record_end;
    logic        stream_done;
    logic [31:0] delta_length;

    // Encoder image held by the testbench.
    logic [7:0]  img_store [CHUNK];
    logic [31:0] img_crc_new  = CRC_INIT;
    logic [31:0] img_crc_old  = CRC_INIT;
    int unsigned img_fill     = 0;
    logic [31:0] img_offset   = '0;
    logic [31:0] img_emitted  = '0;

    delta_word_t pending_deltas [$];
    int          fail_count   = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;

    chunk_crc_delta_encoder #(
        .CHUNK_BYTES (CHUNK)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .new_byte     (new_byte),
        .old_byte     (old_byte),
        .last_in      (last_in),
        .delta_valid  (delta_valid),
        .delta_stall  (delta_stall),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .record_end   (record_end),
        .stream_done  (stream_done),
        .delta_length (delta_length)
    );

    always #2 clk = ~clk;

    // Reflected CRC-32 over one byte, LSB first.
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Count a delta byte and queue it unless the row supplies its own words.
    task automatic queue_record_byte(input logic [7:0] b, input logic rend, input logic done,
                                     input bit keep);
        img_emitted = img_emitted + 32'd1;
        if (keep)
            pending_deltas.push_back('{data: b, has_data: 1'b1, rec_end: rend,
                                       done: done, total: img_emitted});
    endtask

    // Advance the encoder image by one accepted pair word; queue the delta
    // words it causes when keep is set.
    task automatic encode_pair(input logic [7:0] nb, input logic [7:0] ob, input logic last,
                               input bit keep);
        int unsigned len;
        logic        is_end;
        if (img_fill < CHUNK) begin
            img_store[img_fill] = nb;
            img_fill++;
        end
        img_crc_new = crc32_step(img_crc_new, nb);
        img_crc_old = crc32_step(img_crc_old, ob);
        if (img_fill < CHUNK && !last)
            return;

        len = img_fill;
        if (img_crc_new != img_crc_old) begin
            for (int k = 0; k < 4; k++)
                queue_record_byte(8'(img_offset >> (8 * k)), 1'b0, 1'b0, keep);
            queue_record_byte(8'(len), 1'b0, 1'b0, keep);
            queue_record_byte(8'(len >> 8), 1'b0, 1'b0, keep);
            for (int unsigned j = 0; j < len; j++) begin
                is_end = (j + 1 == len);
                queue_record_byte(img_store[j], is_end, is_end & last, keep);
            end
        end else if (last && keep) begin
            pending_deltas.push_back('{data: 8'h00, has_data: 1'b0, rec_end: 1'b0,
                                       done: 1'b1, total: img_emitted});
        end

        img_offset  = img_offset + 32'(len);
        img_fill    = 0;
        img_crc_new = CRC_INIT;
        img_crc_old = CRC_INIT;
        if (last) begin
            img_offset  = '0;
            img_emitted = '0;
        end
    endtask

    // Offer one pair word from the falling edge, in bursts with random gaps;
    // hold it until the block takes it, then update the image.
    task automatic send_pair(input logic [7:0] nb, input logic [7:0] ob, input logic last,
                             input logic typed, input delta_word_t exp);
        if (burst_left == 0) begin
            pair_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        pair_valid <= 1'b1;
        new_byte   <= nb;
        old_byte   <= ob;
        last_in    <= last;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
        // Typed rows keep the image in step but queue the row's own word.
        encode_pair(nb, ob, last, !typed);
        if (typed)
            pending_deltas.push_back(exp);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare every accepted delta word with the oldest expectation.
    always @(posedge clk) begin
        delta_word_t exp_w;
        if (rst_n && delta_valid && !delta_stall) begin
            if (pending_deltas.size() == 0) begin
                $error("delta word with nothing expected: byte 0x%0h len %0d",
                       out_byte, delta_length);
                fail_count++;
            end else begin
                exp_w = pending_deltas.pop_front();
                check_field("out_byte", 32'(exp_w.data), 32'(out_byte));
                check_field("has_byte", 32'(exp_w.has_data), 32'(has_byte));
                check_field("record_end", 32'(exp_w.rec_end), 32'(record_end));
                check_field("stream_done", 32'(exp_w.done), 32'(stream_done));
                check_field("delta_length", exp_w.total, delta_length);
            end
        end
    end

    // Receiver: switch between random stall patterns, with one long hold-off
    // while the sender keeps offering, so the block backs up into pair_stall.
    initial begin
        int rcv_cycle;
        int hold_left;
        int pattern;
        rcv_cycle = 0;
        hold_left = 0;
        pattern   = 0;
        forever begin
            @(negedge clk);
            if (rst_n) begin
                rcv_cycle++;
                if (rcv_cycle == HOLD_START)
                    hold_left = HOLD_LEN;
                if (rcv_cycle % 64 == 0)
                    pattern = $urandom_range(0, 4);
                if (hold_left > 0) begin
                    hold_left--;
                    delta_stall <= 1'b1;
                end else begin
                    case (pattern)
                        0:       delta_stall <= 1'b0;
                        1:       delta_stall <= ($urandom_range(0, 3) == 0);
                        2:       delta_stall <= ($urandom_range(0, 3) != 0);
                        3:       delta_stall <= (rcv_cycle % 3 == 0);
                        default: delta_stall <= ($urandom_range(0, 1) == 1);
                    endcase
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sender: directed table, then random streams.
    initial begin
        int          rand_sent;
        int          stream_len;
        int          diff_mode;
        logic [7:0]  nb;
        logic [7:0]  ob;
        rand_sent = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIR; r++)
            send_pair(dir_rows[r].nb, dir_rows[r].ob, dir_rows[r].last,
                      dir_rows[r].typed, dir_rows[r].exp);

        // Streams: mostly short, a few spanning several full chunks. The
        // difference rate per stream decides how many chunks emit a record.
        while (rand_sent < RAND_ITEMS) begin
            stream_len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 130)
                                                     : $urandom_range(1, 45);
            // Trim the final stream so the random part ends on the item budget.
            if (stream_len > RAND_ITEMS - rand_sent)
                stream_len = RAND_ITEMS - rand_sent;
            diff_mode  = $urandom_range(0, 3);
            for (int i = 0; i < stream_len; i++) begin
                nb = 8'($urandom);
                case (diff_mode)
                    0:       ob = nb;
                    1:       ob = ($urandom_range(0, 39) == 0) ? 8'($urandom) : nb;
                    2:       ob = ($urandom_range(0, 2) == 0) ? 8'($urandom) : nb;
                    default: ob = 8'($urandom);
                endcase
                send_pair(nb, ob, (i == stream_len - 1), 1'b0, NO_EXP);
                rand_sent++;
            end
        end
        pair_valid <= 1'b0;

        // Drain: wait for every expected word, then give stray words time to show.
        while (pending_deltas.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
